FILE: design/srsg_pkg.sv
// Shared types and constants for the stepper ramp step generator.
package srsg_pkg;

   localparam int unsigned ACC_W = 20;
   localparam int unsigned SPD_W = 16;
   localparam int unsigned POS_W = 32;
   localparam int unsigned TSPD_W = 17;
   localparam int unsigned VEL_W = 26;
   localparam int unsigned IVL_W = 20;
   localparam int unsigned OUT_IVL_W = 16;
   localparam int unsigned ERR_W = POS_W + 1;

   localparam int unsigned MUL_A_W = ERR_W;
   localparam int unsigned MUL_B_W = VEL_W;
   localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

   localparam int unsigned DIV_N_W = 48;
   localparam int unsigned DIV_D_W = 26;
   localparam int unsigned DIV_C_W = 6;
   localparam int unsigned DIV_SHORT = 28;

   localparam logic [DIV_N_W-1:0] ONE_MEG = 48'd1000000;
   localparam logic [DIV_N_W-1:0] MEG_Q8 = 48'd256000000;

   // dv = floor(4 * acc * dt / 15625); reciprocal is floor(2^38 / 15625)
   localparam logic [MUL_B_W-1:0] DV_RECIP = 26'd17592186;
   localparam logic [16:0] DV_DIVISOR = 17'd15625;

   localparam logic REG_ACCEL = 1'b0;
   localparam logic REG_START = 1'b1;

   typedef enum logic [1:0] {
      STAT_STEP = 2'd0,
      STAT_ARRIVED = 2'd1,
      STAT_SLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
      logic [DIV_C_W-1:0] count;
   } div_req_type;

endpackage

FILE: design/srsg_mul.sv
// Shared registered multiplier.
module srsg_mul
   import srsg_pkg::*;
(
   input  logic clock,
   input  logic [MUL_A_W-1:0] op_a,
   input  logic [MUL_B_W-1:0] op_b,
   output logic [MUL_P_W-1:0] product
);

   logic [MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
   end

   assign product = prod_ff;

endmodule

FILE: design/srsg_div.sv
// Shared restoring divider, one quotient bit per cycle.
module srsg_div
   import srsg_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  div_req_type req,
   output logic done,
   output logic [DIV_N_W-1:0] quotient
);

   logic busy_ff;
   logic done_ff;
   logic [DIV_C_W-1:0] cnt_ff;
   logic [DIV_N_W-1:0] q_ff;
   logic [DIV_D_W-1:0] rem_ff;
   logic [DIV_D_W-1:0] div_ff;
   logic [DIV_D_W:0] trial;
   logic [DIV_D_W:0] diff;

   assign trial = {rem_ff, q_ff[DIV_N_W-1]};
   assign diff = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= req.count;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_C_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         q_ff <= req.dividend;
         rem_ff <= '0;
         div_ff <= req.divisor;
      end else if (busy_ff) begin
         if (!diff[DIV_D_W]) begin
            rem_ff <= diff[DIV_D_W-1:0];
            q_ff <= {q_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[DIV_D_W-1:0];
            q_ff <= {q_ff[DIV_N_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;

endmodule

FILE: design/stepper_ramp_step_generator_unit.sv
// Top level: sequencer of the stepper ramp step generator.
// A request at target in position mode goes straight to the output state; a step runs the dv
// multiplies, the braking check and the interval division, with a start-speed division first
// from a stop; velocity mode skips the braking check. One request is in flight at a time (ready
// only in idle); the result register lets the next request enter while a result waits.
// Reset: synchronous, clears position, velocity, interval and running; acceleration 1000, start 100.
module stepper_ramp_step_generator_unit
   import srsg_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [55:0] req_tdata,   // target_position[31:0], target_speed[48:32]
   input  logic req_tuser,          // mode
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [55:0] rsp_tdata,   // step_ivl[15:0], direction[16], position[48:17]
   output logic [1:0] rsp_tuser,    // status
   input  logic csr_we,
   input  logic csr_index,
   input  logic [ACC_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_DT, S_MULDT, S_RECIP, S_BACK, S_FIX, S_SQ, S_BRK1, S_BRK2,
      S_RAMP, S_IV, S_OUT
   } state_type;

   state_type state_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [SPD_W-1:0] ss_ff;
   logic [POS_W-1:0] pos_ff;
   logic signed [VEL_W-1:0] vel_ff;
   logic [IVL_W-1:0] last_ff;
   logic running_ff;

   logic mode_ff;
   logic signed [ERR_W-1:0] err_ff;
   logic signed [TSPD_W-1:0] tspd_ff;
   logic signed [VEL_W-1:0] v_ff;
   logic [IVL_W-1:0] dt_ff;
   logic [28:0] dv_ff;
   logic [16:0] wlo_ff;
   logic [49:0] sq_ff;
   logic brake_ff;
   status_type ostat_ff;
   logic [OUT_IVL_W-1:0] oivl_ff;
   logic odir_ff;

   logic rsp_tvalid_ff;
   logic [55:0] rsp_tdata_ff;
   logic [1:0] rsp_tuser_ff;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] product;
   div_req_type div_req;
   logic div_done;
   logic [DIV_N_W-1:0] quotient;

   logic accept;
   logic signed [ERR_W-1:0] in_err;
   logic signed [POS_W-1:0] in_tpos;
   logic [ERR_W-1:0] abs_err;
   logic [VEL_W-1:0] abs_v;
   logic signed [VEL_W-1:0] kick;
   logic [SPD_W-1:0] ss_nz;
   logic signed [29:0] desired;
   logic signed [29:0] verr;
   logic signed [29:0] dv_s;
   logic signed [29:0] vnew_w;
   logic signed [VEL_W-1:0] vnew;
   logic [VEL_W-1:0] abs_vnew;
   logic [69:0] lhs;
   logic [16:0] rem;
   logic [1:0] dv_fix;

   srsg_mul u_mul (
      .clock(clock), .op_a(mul_a), .op_b(mul_b), .product(product)
   );

   srsg_div u_div (
      .clock(clock), .reset(reset), .req(div_req), .done(div_done), .quotient(quotient)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;
   assign in_tpos = req_tdata[31:0];
   assign in_err = ERR_W'(in_tpos) - ERR_W'($signed(pos_ff));
   assign ss_nz = (ss_ff == '0) ? SPD_W'(1) : ss_ff;
   assign kick = (in_err > 0) ? VEL_W'($signed({1'b0, ss_ff, 8'd0}))
                              : -VEL_W'($signed({1'b0, ss_ff, 8'd0}));
   assign abs_err = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
   assign abs_v = v_ff[VEL_W-1] ? VEL_W'(-v_ff) : VEL_W'(v_ff);
   assign lhs = {product[52:0], 17'd0};
   assign rem = wlo_ff - product[16:0];
   assign dv_fix = (rem >= 17'(3 * DV_DIVISOR)) ? 2'd3 :
                   (rem >= 17'(2 * DV_DIVISOR)) ? 2'd2 :
                   (rem >= DV_DIVISOR) ? 2'd1 : 2'd0;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MULDT: begin
            mul_a = MUL_A_W'(acc_ff);
            mul_b = MUL_B_W'(dt_ff);
         end
         S_RECIP: begin
            mul_a = MUL_A_W'(product[39:12]);
            mul_b = DV_RECIP;
         end
         S_BACK: begin
            mul_a = MUL_A_W'(product[52:24]);
            mul_b = MUL_B_W'(DV_DIVISOR);
         end
         S_SQ: begin
            mul_a = MUL_A_W'(abs_v);
            mul_b = abs_v;
         end
         S_BRK1: begin
            mul_a = abs_err;
            mul_b = MUL_B_W'(acc_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (mode_ff) begin
         desired = 30'(tspd_ff) <<< 8;
      end else if (brake_ff) begin
         desired = '0;
      end else if (err_ff > 0) begin
         desired = 30'(tspd_ff) <<< 8;
      end else begin
         desired = -(30'(tspd_ff) <<< 8);
      end
      dv_s = $signed({1'b0, dv_ff});
      verr = desired - 30'(v_ff);
      if (verr > dv_s) begin
         verr = dv_s;
      end else if (verr < -dv_s) begin
         verr = -dv_s;
      end
      vnew_w = 30'(v_ff) + verr;
      vnew = vnew_w[VEL_W-1:0];
      abs_vnew = vnew[VEL_W-1] ? VEL_W'(-vnew) : VEL_W'(vnew);
   end

   always_comb begin
      div_req.start = 1'b0;
      div_req.dividend = '0;
      div_req.divisor = '0;
      div_req.count = '0;
      case (state_ff)
         S_IDLE: begin
            div_req.dividend = ONE_MEG << (DIV_N_W - DIV_SHORT);
            div_req.divisor = DIV_D_W'(ss_nz);
            div_req.count = DIV_C_W'(DIV_SHORT);
            div_req.start = accept && !(in_err == '0 && !req_tuser) && !running_ff;
         end
         S_RAMP: begin
            div_req.start = (abs_vnew >= VEL_W'(256));
            div_req.dividend = MEG_Q8 << (DIV_N_W - DIV_SHORT);
            div_req.divisor = abs_vnew;
            div_req.count = DIV_C_W'(DIV_SHORT);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         acc_ff <= ACC_W'(1000);
         ss_ff <= SPD_W'(100);
         pos_ff <= '0;
         vel_ff <= '0;
         last_ff <= '0;
         running_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_ACCEL) begin
               acc_ff <= csr_wdata;
            end else if (csr_index == REG_START) begin
               ss_ff <= csr_wdata[SPD_W-1:0];
            end
         end
         if (state_ff == S_OUT && (!rsp_tvalid_ff || rsp_tready)) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_tdata_ff <= {7'd0, pos_ff, odir_ff, oivl_ff};
            rsp_tuser_ff <= ostat_ff;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  mode_ff <= req_tuser;
                  err_ff <= in_err;
                  tspd_ff <= req_tdata[48:32];
                  brake_ff <= 1'b0;
                  if (req_tuser && vel_ff < VEL_W'(256) && vel_ff > -VEL_W'(256)) begin
                     v_ff <= kick;
                  end else begin
                     v_ff <= vel_ff;
                  end
                  if (in_err == '0 && !req_tuser) begin
                     vel_ff <= '0;
                     running_ff <= 1'b0;
                     ostat_ff <= STAT_ARRIVED;
                     oivl_ff <= '0;
                     odir_ff <= 1'b0;
                     state_ff <= S_OUT;
                  end else if (running_ff) begin
                     dt_ff <= last_ff;
                     state_ff <= S_MULDT;
                  end else begin
                     state_ff <= S_DT;
                  end
               end
            end
            S_DT: begin
               if (div_done) begin
                  dt_ff <= quotient[IVL_W-1:0];
                  state_ff <= S_MULDT;
               end
            end
            S_MULDT: state_ff <= S_RECIP;
            S_RECIP: begin
               wlo_ff <= {product[14:0], 2'b00};
               state_ff <= S_BACK;
            end
            S_BACK: begin
               dv_ff <= product[52:24];
               state_ff <= S_FIX;
            end
            S_FIX: begin
               dv_ff <= dv_ff + 29'(dv_fix);
               state_ff <= mode_ff ? S_RAMP : S_SQ;
            end
            S_SQ: state_ff <= S_BRK1;
            S_BRK1: begin
               sq_ff <= product[49:0];
               state_ff <= S_BRK2;
            end
            S_BRK2: begin
               brake_ff <= (lhs <= 70'(sq_ff));
               state_ff <= S_RAMP;
            end
            S_RAMP: begin
               vel_ff <= vnew;
               v_ff <= vnew;
               if (abs_vnew < VEL_W'(256)) begin
                  running_ff <= 1'b0;
                  ostat_ff <= STAT_SLOW;
                  oivl_ff <= '0;
                  odir_ff <= 1'b0;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_IV;
               end
            end
            S_IV: begin
               if (div_done) begin
                  last_ff <= quotient[IVL_W-1:0];
                  running_ff <= 1'b1;
                  pos_ff <= v_ff[VEL_W-1] ? pos_ff - 1'b1 : pos_ff + 1'b1;
                  ostat_ff <= STAT_STEP;
                  oivl_ff <= (quotient[IVL_W-1:0] > IVL_W'(65535)) ? 16'hFFFF
                                                                   : quotient[15:0];
                  odir_ff <= !v_ff[VEL_W-1];
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

endmodule
